### src/interval_range_allocator_defines.svh
`ifndef INTERVAL_RANGE_ALLOCATOR_DEFINES_SVH
`define INTERVAL_RANGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ira check failed");

// next-cycle implication, checked outside reset
`define IRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ira check failed");

`endif

### src/ira_pkg.sv
`timescale 1ns / 1ps
package ira_pkg;

  localparam int MAX_BOUNDS = 64;
  localparam int ADDR_W     = $clog2(MAX_BOUNDS);
  localparam int CNT_W      = $clog2(MAX_BOUNDS + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOT_ALLOC = 3'd2,
    ST_BEYOND    = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_RD_IDX,
    OP_RD_LAST,
    OP_HI,
    OP_END,
    OP_NEXT,
    OP_NEXTR,
    OP_WR_LO,
    OP_WR_HI,
    OP_INS_INIT,
    OP_INS_STEP,
    OP_INS_DONE,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic cnt_zero;
    logic idx_at_count;
    logic idx_zero;
    logic idx_cand;
    logic idx_last;
    logic rd_gt_off;
    logic fit;
    logic end_eq_hi;
    logic lo_eq_off;
    logic off_lt_lo;
    logic full;
    logic ins_done;
    logic res_busy;
  } dp_stat_t;

endpackage

### src/interval_range_allocator.sv
`timescale 1ns / 1ps
// channel   | handshake                    | word
// ----------+------------------------------+-------------------------------------------
// request   | in_valid_i / in_ready_o      | func, request_size, align_log2, free_offset
// result    | out_valid_o / out_ready_i    | status, alloc_offset
// config    | cfg_valid_i / cfg_ready_o    | space_limit
//
// One request at a time. Allocate scans the boundary list with a read, align,
// end sum and fit test per boundary; free scans with a read and a check per
// boundary. A pair insert with merge rewrites the list from the insert point,
// one memory word per cycle.
// Reset empties the list and sets space_limit to all ones; no clearing pass.
// The result register frees the request side: a new word is taken while a
// result waits, and the next result stalls only until the old one is taken.
`include "interval_range_allocator_defines.svh"
module interval_range_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [31:0] request_size_i,
  input  logic [4:0]  align_log2_i,
  input  logic [31:0] free_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] alloc_offset_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] space_limit_i
);

  ira_pkg::dp_cmd_t  cmd;
  ira_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ira_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ira_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .request_size_i (request_size_i),
    .align_log2_i   (align_log2_i),
    .free_offset_i  (free_offset_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (space_limit_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .alloc_offset_o (alloc_offset_o)
  );

  `IRA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `IRA_ASSERT_NOW(a_err_offset_zero, out_valid_o && status_o != ira_pkg::ST_OK, ~|alloc_offset_o)
  `IRA_ASSERT_NOW(a_status_legal, out_valid_o, status_o <= ira_pkg::ST_FULL)
  `IRA_ASSERT_NOW(a_insert_has_room, cmd.op == ira_pkg::OP_INS_INIT, !stat.full)

endmodule

### src/ira_datapath.sv
`timescale 1ns / 1ps
module ira_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ira_pkg::dp_cmd_t       cmd_i,
  output ira_pkg::dp_stat_t      stat_o,
  input  logic                   func_i,
  input  logic [31:0]            request_size_i,
  input  logic [4:0]             align_log2_i,
  input  logic [31:0]            free_offset_i,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [2:0]             status_o,
  output logic [31:0]            alloc_offset_o
);

  localparam int AW = ira_pkg::ADDR_W;
  localparam int CW = ira_pkg::CNT_W;

  logic [31:0]   mem [ira_pkg::MAX_BOUNDS];

  logic [CW-1:0] count_q, idx_q, wr_q, rp_q, n_q;
  logic [CW-1:0] cnt_m1, wr_n;
  logic [1:0]    sel_q;
  logic [31:0]   lo_q, hi_q, rdata_q, dly_q, prev_q, size_q, limit_q;
  logic [32:0]   off_q, aligned;
  logic [33:0]   end_q;
  logic [4:0]    align_q;
  logic          func_q;
  logic [31:0]   mask, cur;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;
  logic [CW:0]   cnt_p2;
  logic          out_valid_q;
  ira_pkg::status_e res_status_q;
  logic [31:0]   res_offset_q;

  assign cnt_m1  = count_q - CW'(1);
  assign cnt_p2  = {1'b0, count_q} + (CW+1)'(2);
  assign mask    = (32'd1 << align_q) - 32'd1;
  // carry out of the round-up stays, so an edge past 32 bits never fits
  assign aligned = ({1'b0, lo_q} + {1'b0, mask}) & {1'b1, ~mask};

  always_comb begin
    unique case (sel_q)
      2'd0:    cur = off_q[31:0];
      2'd1:    cur = end_q[31:0];
      default: cur = dly_q;
    endcase
  end

  // pop two written entries on a repeat; a lone leading entry pops by one
  always_comb begin
    if (prev_q == cur) begin
      wr_n = (wr_q == '0) ? '0 : wr_q - CW'(1);
    end else begin
      wr_n = wr_q + CW'(1);
    end
  end

  always_comb begin
    rd_addr = idx_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = cur;
    unique case (cmd_i.op)
      ira_pkg::OP_RD_LAST: rd_addr = cnt_m1[AW-1:0];
      ira_pkg::OP_WR_LO: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AW-1:0] - AW'(1);
        wr_data = end_q[31:0];
      end
      ira_pkg::OP_WR_HI: begin
        wr_en   = 1'b1;
        wr_data = off_q[31:0];
      end
      ira_pkg::OP_INS_STEP: begin
        rd_addr = rp_q[AW-1:0];
        wr_en   = 1'b1;
        wr_addr = wr_q[AW-1:0];
      end
      default: ;
    endcase
  end

  // read sees the old word when the same address is written at the same edge
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q <= rdata_q;
    unique case (cmd_i.op)
      ira_pkg::OP_INIT: begin
        func_q  <= func_i;
        size_q  <= request_size_i;
        align_q <= align_log2_i;
        off_q   <= {1'b0, free_offset_i};
        idx_q   <= '0;
        lo_q    <= '0;
      end
      ira_pkg::OP_HI: begin
        hi_q <= (idx_q == count_q) ? limit_q : rdata_q;
        if (!func_q) begin
          off_q <= aligned;
        end
      end
      ira_pkg::OP_END: end_q <= {1'b0, off_q} + {2'b00, size_q};
      ira_pkg::OP_NEXT: begin
        lo_q  <= hi_q;
        idx_q <= idx_q + CW'(1);
      end
      ira_pkg::OP_NEXTR: begin
        lo_q  <= rdata_q;
        idx_q <= idx_q + CW'(1);
      end
      ira_pkg::OP_INS_INIT: begin
        wr_q   <= idx_q;
        rp_q   <= idx_q;
        prev_q <= lo_q;
        sel_q  <= 2'd0;
        n_q    <= count_q - idx_q + CW'(2);
      end
      ira_pkg::OP_INS_STEP: begin
        rp_q   <= rp_q + CW'(1);
        sel_q  <= (sel_q == 2'd2) ? 2'd2 : sel_q + 2'd1;
        n_q    <= n_q - CW'(1);
        wr_q   <= wr_n;
        prev_q <= (prev_q == cur) ? 32'd0 : cur;
      end
      ira_pkg::OP_RESULT: begin
        res_status_q <= cmd_i.status;
        res_offset_q <= (cmd_i.status == ira_pkg::ST_OK && !func_q) ? off_q[31:0] : 32'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= 32'hFFFF_FFFF;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == ira_pkg::OP_INS_DONE) begin
        count_q <= wr_q;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (cmd_i.op == ira_pkg::OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.func         = func_q;
    stat_o.cnt_zero     = (count_q == '0);
    stat_o.idx_at_count = (idx_q == count_q);
    stat_o.idx_zero     = (idx_q == '0);
    stat_o.idx_cand     = (idx_q[0] == count_q[0]);
    stat_o.idx_last     = (idx_q == cnt_m1);
    stat_o.rd_gt_off    = (rdata_q > off_q[31:0]);
    stat_o.fit          = (end_q <= {2'b00, hi_q});
    stat_o.end_eq_hi    = (end_q == {2'b00, hi_q});
    stat_o.lo_eq_off    = ({1'b0, lo_q} == off_q);
    stat_o.off_lt_lo    = (off_q < {1'b0, lo_q});
    stat_o.full         = (cnt_p2 > (CW+1)'(ira_pkg::MAX_BOUNDS));
    stat_o.ins_done     = (n_q == '0);
    stat_o.res_busy     = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_status_q;
  assign alloc_offset_o = res_offset_q;

endmodule

### src/ira_ctrl.sv
`timescale 1ns / 1ps
module ira_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ira_pkg::dp_stat_t  stat_i,
  output ira_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DISP  = 14'b00000000000010,
    S_ARD   = 14'b00000000000100,
    S_AHI   = 14'b00000000001000,
    S_AEND  = 14'b00000000010000,
    S_ACHK  = 14'b00000000100000,
    S_FPRE  = 14'b00000001000000,
    S_FPRE2 = 14'b00000010000000,
    S_FRD   = 14'b00000100000000,
    S_FCHK  = 14'b00001000000000,
    S_FEND  = 14'b00010000000000,
    S_FEVAL = 14'b00100000000000,
    S_INS   = 14'b01000000000000,
    S_RES   = 14'b10000000000000
  } state_e;

  state_e           state_q, state_d;
  ira_pkg::status_e status_q, status_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    cmd_o.op     = ira_pkg::OP_NONE;
    cmd_o.status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ira_pkg::OP_INIT;
          state_d  = S_DISP;
        end
      end
      S_DISP: state_d = stat_i.func ? S_FPRE : S_ARD;
      S_ARD: begin
        cmd_o.op = ira_pkg::OP_RD_IDX;
        state_d  = S_AHI;
      end
      S_AHI: begin
        cmd_o.op = ira_pkg::OP_HI;
        state_d  = S_AEND;
      end
      S_AEND: begin
        cmd_o.op = ira_pkg::OP_END;
        state_d  = S_ACHK;
      end
      S_ACHK: begin
        if (stat_i.idx_cand && stat_i.fit) begin
          if (stat_i.idx_zero || stat_i.end_eq_hi) begin
            if (stat_i.full) begin
              status_d = ira_pkg::ST_FULL;
              state_d  = S_RES;
            end else begin
              cmd_o.op = ira_pkg::OP_INS_INIT;
              state_d  = S_INS;
            end
          end else begin
            // grow the used segment below
            cmd_o.op = ira_pkg::OP_WR_LO;
            status_d = ira_pkg::ST_OK;
            state_d  = S_RES;
          end
        end else if (stat_i.idx_at_count) begin
          status_d = ira_pkg::ST_NO_SPACE;
          state_d  = S_RES;
        end else begin
          cmd_o.op = ira_pkg::OP_NEXT;
          state_d  = S_ARD;
        end
      end
      S_FPRE: begin
        if (stat_i.cnt_zero) begin
          status_d = ira_pkg::ST_NOT_ALLOC;
          state_d  = S_RES;
        end else begin
          cmd_o.op = ira_pkg::OP_RD_LAST;
          state_d  = S_FPRE2;
        end
      end
      S_FPRE2: begin
        if (!stat_i.rd_gt_off) begin
          status_d = ira_pkg::ST_NOT_ALLOC;
          state_d  = S_RES;
        end else begin
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        cmd_o.op = ira_pkg::OP_RD_IDX;
        state_d  = S_FCHK;
      end
      S_FCHK: begin
        if (!stat_i.idx_cand && (stat_i.rd_gt_off || stat_i.idx_last)) begin
          cmd_o.op = ira_pkg::OP_HI;
          state_d  = S_FEND;
        end else begin
          cmd_o.op = ira_pkg::OP_NEXTR;
          state_d  = S_FRD;
        end
      end
      S_FEND: begin
        cmd_o.op = ira_pkg::OP_END;
        state_d  = S_FEVAL;
      end
      S_FEVAL: begin
        priority if (stat_i.off_lt_lo || !stat_i.fit) begin
          status_d = ira_pkg::ST_BEYOND;
          state_d  = S_RES;
        end else if (!stat_i.idx_zero && stat_i.lo_eq_off && !stat_i.end_eq_hi) begin
          cmd_o.op = ira_pkg::OP_WR_LO;
          status_d = ira_pkg::ST_OK;
          state_d  = S_RES;
        end else if (!stat_i.lo_eq_off && stat_i.end_eq_hi) begin
          cmd_o.op = ira_pkg::OP_WR_HI;
          status_d = ira_pkg::ST_OK;
          state_d  = S_RES;
        end else if (stat_i.full) begin
          status_d = ira_pkg::ST_FULL;
          state_d  = S_RES;
        end else begin
          cmd_o.op = ira_pkg::OP_INS_INIT;
          state_d  = S_INS;
        end
      end
      S_INS: begin
        if (stat_i.ins_done) begin
          cmd_o.op = ira_pkg::OP_INS_DONE;
          status_d = ira_pkg::ST_OK;
          state_d  = S_RES;
        end else begin
          cmd_o.op = ira_pkg::OP_INS_STEP;
        end
      end
      S_RES: begin
        if (!stat_i.res_busy) begin
          cmd_o.op = ira_pkg::OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ira_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

### tb/sv/interval_range_allocator_test.sv
`timescale 1ns / 1ps
module interval_range_allocator_test;

  localparam int          SETTLE_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT   = 4000000;

  typedef struct packed {
    ira_pkg::status_e status;
    logic [31:0]      offset;
  } alloc_result_t;

  typedef struct {
    logic [31:0] base;
    logic [31:0] size;
  } live_range_t;

  // Tracks the boundary list and the queue of results still owed by the block.
  class range_scoreboard;
    logic [31:0]   bounds[ira_pkg::MAX_BOUNDS];
    int            nbounds;
    logic [31:0]   limit;
    alloc_result_t owed[$];
    int            errors;
    int            status_seen[5];
    int            results_checked;

    function new();
      nbounds = 0;
      limit   = 32'hFFFF_FFFF;
      errors  = 0;
      results_checked = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void fail(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    // new pair goes in before pos, then repeated boundaries collapse
    function void insert_pair(int pos, logic [31:0] lo, logic [31:0] hi);
      int rd;
      int wr;
      logic [31:0] prev;
      logic [31:0] cur;
      for (int k = nbounds; k > pos; k--) bounds[k + 1] = bounds[k - 1];
      bounds[pos]     = lo;
      bounds[pos + 1] = hi;
      nbounds += 2;
      rd   = pos;
      wr   = pos;
      prev = (pos == 0) ? 32'd0 : bounds[pos - 1];
      while (rd < nbounds) begin
        cur = bounds[rd];
        rd++;
        bounds[wr] = cur;
        wr++;
        if (prev == cur) begin
          wr -= (wr == 1) ? 1 : 2;
          cur = 32'd0;
        end
        prev = cur;
      end
      nbounds = wr;
    endfunction

    function ira_pkg::status_e place(logic [63:0] size, logic [4:0] align,
                                     output logic [31:0] off_o);
      int i;
      logic [63:0] mask;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] off;
      logic [63:0] fin;
      off_o = '0;
      i     = nbounds & 1;
      mask  = (64'd1 << align) - 64'd1;
      while (i <= nbounds) begin
        lo  = (i == 0) ? 64'd0 : {32'd0, bounds[i - 1]};
        hi  = (i == nbounds) ? {32'd0, limit} : {32'd0, bounds[i]};
        off = (lo + mask) & ~mask;
        fin = off + size;
        if (fin <= hi) begin
          if (i == 0 || fin == hi) begin
            if (nbounds + 2 > ira_pkg::MAX_BOUNDS) return ira_pkg::ST_FULL;
            insert_pair(i, off[31:0], fin[31:0]);
          end else begin
            bounds[i - 1] = fin[31:0];
          end
          off_o = off[31:0];
          return ira_pkg::ST_OK;
        end
        i += 2;
      end
      return ira_pkg::ST_NO_SPACE;
    endfunction

    function ira_pkg::status_e release_range(logic [63:0] off, logic [63:0] size);
      int i;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] fin;
      if (nbounds == 0 || {32'd0, bounds[nbounds - 1]} <= off) return ira_pkg::ST_NOT_ALLOC;
      i = 1 - (nbounds & 1);
      while (i < nbounds - 1 && {32'd0, bounds[i]} <= off) i += 2;
      lo  = (i == 0) ? 64'd0 : {32'd0, bounds[i - 1]};
      hi  = {32'd0, bounds[i]};
      fin = off + size;
      if (off < lo || hi < fin) return ira_pkg::ST_BEYOND;
      if (i != 0 && lo == off && fin != hi) begin
        bounds[i - 1] = fin[31:0];
      end else if (lo != off && fin == hi) begin
        bounds[i] = off[31:0];
      end else begin
        if (nbounds + 2 > ira_pkg::MAX_BOUNDS) return ira_pkg::ST_FULL;
        insert_pair(i, off[31:0], fin[31:0]);
      end
      return ira_pkg::ST_OK;
    endfunction

    // accepted request word: predict and queue the result
    function alloc_result_t note_request(logic func, logic [31:0] size, logic [4:0] align,
                                         logic [31:0] off);
      alloc_result_t r;
      logic [31:0] placed;
      if (func == 1'b0) r.status = place({32'd0, size}, align, placed);
      else begin
        r.status = release_range({32'd0, off}, {32'd0, size});
        placed   = '0;
      end
      r.offset = (r.status == ira_pkg::ST_OK) ? placed : 32'd0;
      owed.push_back(r);
      return r;
    endfunction

    function void check_result(logic [2:0] status, logic [31:0] offset);
      alloc_result_t e;
      results_checked++;
      if (owed.size() == 0) begin
        fail($sformatf("unexpected result status=%0d offset=%h", status, offset));
        return;
      end
      e = owed.pop_front();
      if (status < 5) status_seen[status]++;
      if (status !== e.status)
        fail($sformatf("status exp %0d got %0d", e.status, status));
      if (offset !== e.offset)
        fail($sformatf("alloc_offset exp %h got %h", e.offset, offset));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [31:0] request_size_i = '0;
  logic [4:0]  align_log2_i = '0;
  logic [31:0] free_offset_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] alloc_offset_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] space_limit_i = '0;

  range_scoreboard board = new();
  live_range_t     live[$];
  int unsigned     cycles = 0;
  int              burst_left = 0;
  int              requests_sent = 0;

  interval_range_allocator dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .func_i, .request_size_i, .align_log2_i, .free_offset_i,
    .out_valid_o, .out_ready_i, .status_o, .alloc_offset_o,
    .cfg_valid_i, .cfg_ready_o, .space_limit_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: rotates among four stall styles
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(status_o, alloc_offset_o);
    case ((cycles / 300) % 4)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((cycles % 64) > 40);
    endcase
  end

  task automatic send_word(logic func, logic [31:0] size, logic [4:0] align,
                           logic [31:0] off);
    alloc_result_t r;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i     <= 1'b1;
    func_i         <= func;
    request_size_i <= size;
    align_log2_i   <= align;
    free_offset_i  <= off;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    requests_sent++;
    r = board.note_request(func, size, align, off);
    if (func == 1'b0 && r.status == ira_pkg::ST_OK && size != 0)
      live.push_back('{r.offset, size});
    if (func == 1'b1 && r.status == ira_pkg::ST_OK) trim_live(off, size);
  endtask

  // keep the list of held ranges in step with a successful free
  function automatic void trim_live(logic [31:0] off, logic [31:0] size);
    logic [32:0] fin;
    logic [32:0] lfin;
    fin = {1'b0, off} + size;
    foreach (live[k]) begin
      lfin = {1'b0, live[k].base} + live[k].size;
      if (off >= live[k].base && fin <= lfin && size != 0) begin
        if (fin != lfin) live.push_back('{fin[31:0], 32'(lfin - fin)});
        if (off == live[k].base) live.delete(k);
        else live[k].size = off - live[k].base;
        return;
      end
    end
  endfunction

  task automatic write_limit(logic [31:0] value);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    space_limit_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.limit = value;
  endtask

  function automatic logic [31:0] pick_size(logic [31:0] span);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'd0;
      default: return $urandom_range(1, span);
    endcase
  endfunction

  task automatic random_item(logic [31:0] span);
    live_range_t lr;
    logic [31:0] cut;
    int          k;
    int          mode;
    mode = $urandom_range(0, 99);
    if (mode < 45 || live.size() == 0) begin
      send_word(1'b0, pick_size(span),
                ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6)),
                $urandom);
    end else if (mode < 90) begin
      k  = $urandom_range(0, live.size() - 1);
      lr = live[k];
      cut = $urandom_range(0, lr.size - 1);
      case ($urandom_range(0, 4))
        0: send_word(1'b1, lr.size, 5'($urandom), lr.base);
        1: send_word(1'b1, cut + 1, 5'($urandom), lr.base);
        2: send_word(1'b1, lr.size - cut, 5'($urandom), lr.base + cut);
        3: send_word(1'b1, (lr.size - cut > 1) ? 32'd1 : 32'd0, 5'($urandom), lr.base + cut);
        default: send_word(1'b1, lr.size + 1, 5'($urandom), lr.base + cut);
      endcase
    end else begin
      send_word($urandom_range(0, 1), $urandom, 5'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, whole space, alignment edges, bad frees
    send_word(1'b1, 32'd1, 5'd0, 32'd0);
    send_word(1'b0, 32'd0, 5'd0, 32'hFFFF_FFFF);
    send_word(1'b0, 32'hFFFF_FFFF, 5'd0, 32'd0);
    send_word(1'b0, 32'd1, 5'd0, 32'd0);
    send_word(1'b1, 32'd1, 5'd0, 32'hFFFF_FFFF);
    send_word(1'b1, 32'd16, 5'd0, 32'h100);
    send_word(1'b1, 32'h10, 5'd0, 32'hFFFF_FFF0);
    send_word(1'b1, 32'hFFFF_FFEF, 5'd0, 32'd1);
    send_word(1'b1, 32'd0, 5'd0, 32'd5);
    send_word(1'b1, 32'd1, 5'd0, 32'd0);
    send_word(1'b0, 32'd1, 5'd31, 32'd0);
    send_word(1'b0, 32'h8000_0000, 5'd31, 32'd0);
    send_word(1'b0, 32'h7FFF_FFFF, 5'd31, 32'd0);
    send_word(1'b1, 32'h8000_0000, 5'd0, 32'h4000_0000);
    send_word(1'b1, 32'h100, 5'd0, 32'h1000);
    send_word(1'b0, 32'h40, 5'd5, 32'd0);
    send_word(1'b0, 32'd3, 5'd4, 32'd0);
    send_word(1'b1, 32'd0, 5'd0, 32'h10);
    send_word(1'b1, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);

    // limit below the last boundary, then the tiny, zero, random and full settings
    write_limit(32'h0000_0100);
    send_word(1'b0, 32'd1, 5'd0, 32'd0);
    write_limit(32'h0000_FFFF);
    repeat (450) random_item(32'h100);
    write_limit(32'd0);
    repeat (150) random_item(32'h10);
    write_limit($urandom);
    repeat (450) random_item(32'h10000);
    write_limit(32'hFFFF_FFFF);
    repeat (600) random_item(32'h1000);

    in_valid_i <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d requests, %0d results: ok %0d, no space %0d, not allocated %0d,",
             requests_sent, board.results_checked, board.status_seen[ira_pkg::ST_OK],
             board.status_seen[ira_pkg::ST_NO_SPACE],
             board.status_seen[ira_pkg::ST_NOT_ALLOC]);
    $display("extends beyond %0d, table full %0d, %0d mismatches",
             board.status_seen[ira_pkg::ST_BEYOND], board.status_seen[ira_pkg::ST_FULL],
             board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
